@@ rtl/core/bdpc_pkg.sv @@
// ----------------------------------------------------------------------------
// bdpc_pkg: shared constants for the button debounce press classifier
// Register byte addresses, reset values and press state codes.
// ----------------------------------------------------------------------------
package bdpc_pkg;

  // apb register map
  localparam int unsigned AddrWidth = 4;
  localparam logic [AddrWidth-1:0] RegDebounceMs  = 4'h0;
  localparam logic [AddrWidth-1:0] RegLongPressMs = 4'h4;
  localparam logic [AddrWidth-1:0] RegIdleLevel   = 4'h8;

  // register reset values
  localparam logic [15:0] DebounceMsRst  = 16'd25;
  localparam logic [15:0] LongPressMsRst = 16'd3000;
  localparam logic        IdleLevelRst   = 1'b1;

  // press state codes
  localparam logic [1:0] StOff   = 2'd0;
  localparam logic [1:0] StShort = 2'd1;
  localparam logic [1:0] StLong  = 2'd2;
  localparam logic [1:0] StWait  = 2'd3;

endpackage

@@ rtl/core/button_debounce_press_classifier.sv @@
// ----------------------------------------------------------------------------
// button_debounce_press_classifier: debounced button with press classification
// Debounces polled button samples and reports long pushes and clicks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one transaction is one poll carrying raw_level_i and the
//   free-running millisecond timestamp now_ms_i. It is taken at a rising edge
//   with in_valid_i high and in_stall_o low.
//   Output channel: one transaction per poll with the debounced level and the
//   pushed-long / clicked flags, all as they stand after that poll.
//   A poll's result is registered: it is in the output register on the
//   edge after it is taken. Throughput is one poll per cycle unless the
//   output is stalled; the state update is one subtract/compare pass.
//   When the receiver stalls, the output register holds its transaction and
//   in_stall_o rises only while that full register is stalled; a poll may be
//   taken in the same cycle the pending result is taken.
//   Reset clears the press machine and debounce timer, restores the register
//   defaults (25 ms debounce, 3000 ms long press, idle level 1) and sets the
//   debounced level to the idle level. Registers must be written over APB only
//   while no poll is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // apb configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bdpc_pkg::AddrWidth-1:0]     paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  // poll input
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               raw_level_i,
  input  logic [31:0]                        now_ms_i,
  // result output
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               level_o,
  output logic                               pushed_long_o,
  output logic                               clicked_short_o,
  output logic                               clicked_long_o,
  output logic                               clicked_any_o
);

  logic [15:0] debounce_ms_q;
  logic [15:0] long_press_ms_q;
  logic        idle_level_q;

  logic        deb_level_q, deb_level_d;
  logic [1:0]  press_state_q, press_state_d;
  logic [31:0] press_start_q, press_start_d;
  logic [31:0] deb_start_q, deb_start_d;
  logic        deb_armed_q, deb_armed_d;

  logic        out_valid_q;
  logic        level_q, pushed_long_q, clicked_short_q, clicked_long_q;

  logic        accept;
  logic        cfg_wr;
  logic [1:0]  st_pre;
  logic [31:0] ps_pre;
  logic [31:0] press_elapsed;
  logic [31:0] deb_elapsed;
  logic        released;

  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite;
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ms_q   <= bdpc_pkg::DebounceMsRst;
      long_press_ms_q <= bdpc_pkg::LongPressMsRst;
      idle_level_q    <= bdpc_pkg::IdleLevelRst;
    end else if (cfg_wr) begin
      unique case (paddr)
        bdpc_pkg::RegDebounceMs:  debounce_ms_q   <= pwdata[15:0];
        bdpc_pkg::RegLongPressMs: long_press_ms_q <= pwdata[15:0];
        bdpc_pkg::RegIdleLevel:   idle_level_q    <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (paddr)
      bdpc_pkg::RegDebounceMs:  prdata = {16'd0, debounce_ms_q};
      bdpc_pkg::RegLongPressMs: prdata = {16'd0, long_press_ms_q};
      bdpc_pkg::RegIdleLevel:   prdata = {31'd0, idle_level_q};
      default:                  prdata = 32'd0;
    endcase
  end

  // press machine: drop to off on release, then advance
  always_comb begin
    st_pre = press_state_q;
    ps_pre = press_start_q;
    if (deb_level_q == idle_level_q && press_state_q != bdpc_pkg::StOff) begin
      st_pre = bdpc_pkg::StOff;
      ps_pre = 32'd0;
    end
    press_elapsed = now_ms_i - ps_pre;
    press_state_d = st_pre;
    press_start_d = ps_pre;
    unique case (st_pre)
      bdpc_pkg::StOff: begin
        if (deb_level_q != idle_level_q) begin
          press_state_d = bdpc_pkg::StShort;
          press_start_d = now_ms_i;
        end
      end
      bdpc_pkg::StShort, bdpc_pkg::StWait: begin
        if (press_elapsed >= {16'd0, long_press_ms_q}) begin
          press_state_d = bdpc_pkg::StLong;
          press_start_d = now_ms_i;
        end
      end
      bdpc_pkg::StLong: press_state_d = bdpc_pkg::StWait;
      default:          press_state_d = bdpc_pkg::StOff;
    endcase
  end

  // debounce timer
  always_comb begin
    deb_elapsed = now_ms_i - deb_start_q;
    deb_level_d = deb_level_q;
    deb_start_d = deb_start_q;
    deb_armed_d = deb_armed_q;
    if (deb_level_q != raw_level_i) begin
      if (!deb_armed_q) begin
        deb_armed_d = 1'b1;
        deb_start_d = now_ms_i;
      end else if (deb_elapsed >= {16'd0, debounce_ms_q}) begin
        deb_level_d = raw_level_i;
      end
    end else begin
      deb_armed_d = 1'b0;
    end
  end

  assign released = (deb_level_d == idle_level_q);

  // state update per accepted poll
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_level_q   <= bdpc_pkg::IdleLevelRst;
      press_state_q <= bdpc_pkg::StOff;
      press_start_q <= 32'd0;
      deb_start_q   <= 32'd0;
      deb_armed_q   <= 1'b0;
    end else if (accept) begin
      deb_level_q   <= deb_level_d;
      press_state_q <= press_state_d;
      press_start_q <= press_start_d;
      deb_start_q   <= deb_start_d;
      deb_armed_q   <= deb_armed_d;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      level_q         <= deb_level_d;
      pushed_long_q   <= (press_state_d == bdpc_pkg::StLong);
      clicked_short_q <= released && (press_state_d == bdpc_pkg::StShort);
      clicked_long_q  <= released && (press_state_d == bdpc_pkg::StLong ||
                                      press_state_d == bdpc_pkg::StWait);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign level_o         = level_q;
  assign pushed_long_o   = pushed_long_q;
  assign clicked_short_o = clicked_short_q;
  assign clicked_long_o  = clicked_long_q;
  assign clicked_any_o   = clicked_short_q | clicked_long_q;

endmodule

@@ rtl/core/bdpc_checker.sv @@
// ----------------------------------------------------------------------------
// bdpc_checker: port-level checks for the press classifier
// Watches the handshakes and result flags of the top level over time.
// ----------------------------------------------------------------------------
module bdpc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic pushed_long_o,
  input logic clicked_short_o,
  input logic clicked_long_o,
  input logic clicked_any_o
);

  // a stalled result transaction stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // every accepted poll yields a result on the next edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted poll gave no result");

  // input stalls only behind a full, stalled output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without back pressure");

  // short and long click are exclusive and any-click is their union
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(clicked_short_o && clicked_long_o) &&
                    (clicked_any_o == (clicked_short_o || clicked_long_o)))
    else $error("inconsistent click flags");

  // a long push is never reported as a short click
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pushed_long_o |-> !clicked_short_o)
    else $error("long push flagged as short click");

endmodule

bind button_debounce_press_classifier bdpc_checker u_bdpc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .pushed_long_o   (pushed_long_o),
  .clicked_short_o (clicked_short_o),
  .clicked_long_o  (clicked_long_o),
  .clicked_any_o   (clicked_any_o)
);
